FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under synchronous active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator
package ffra_pkg;

    localparam int unsigned MAX_RANGES_DEF = 16;
    localparam int unsigned ADDR_BITS_DEF  = 32;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned END_W          = DATA_W + 1;
    localparam int unsigned CFG_AW         = 3;

    localparam logic [DATA_W-1:0] BUF_BYTES_RST = 32'd65536;

    // Register index taken from paddr[2]
    localparam logic REG_BUFFER_BYTES = 1'b0;

    // Request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_MOVE,
        S_PUT
    } t_state;

    // One table entry: a live range
    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] size;
    } t_entry;

endpackage

FILE: rtl/first_fit_range_allocator.sv
// First-fit range allocator: one request in flight, result strobed for one cycle.
// A rejected request is answered from idle; others scan the live entries, the table read port
// moving one entry a cycle. An allocate shifts the tail up at a fitting gap, else tries the
// gap at the buffer end, and puts the range on a fit; a found release shifts later ones down.
// busy is low again in the cycle o_done is shown, so the next word may be taken then.
// Synchronous reset clears the live entry count and sets buffer_bytes to 65536; the receiver cannot stall.
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [DATA_W-1:0] i_req_size,
    input  logic [DATA_W-1:0] i_req_offset,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_grant_offset,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [END_W-1:0] buf_end;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    t_entry           wdata;
    t_entry           rd_data;

    // Configuration registers
    ffra_cfg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_buf_end (buf_end)
    );

    // Sequencer
    ffra_ctrl #(
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_opcode       (i_opcode),
        .i_req_size     (i_req_size),
        .i_req_offset   (i_req_offset),
        .i_buf_end      (buf_end),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rd_data      (rd_data),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_grant_offset (o_grant_offset)
    );

    // Range table
    ffra_table #(
        .MAX_RANGES (MAX_RANGES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr   (raddr),
        .o_rd_data (rd_data)
    );

endmodule

FILE: rtl/ffra_table.sv
// Range table memory: one write port, one registered read port
module ffra_table
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_RANGES];
    t_entry r_rd_data;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ffra_cfg.sv
// APB register block holding the buffer size and its clamped end
module ffra_cfg
    import ffra_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [END_W-1:0]  o_buf_end
);

    // Address space limit; no clamp once it reaches the register range
    localparam int unsigned    LIM_SH = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
    localparam logic [END_W-1:0] LIMIT = END_W'(1) << LIM_SH;

    logic [DATA_W-1:0] r_buf_bytes;
    logic [END_W-1:0]  r_buf_end;
    logic [END_W-1:0]  wr_ext;
    logic [END_W-1:0]  rst_ext;
    logic              wr_en;

    assign wr_en   = psel && penable && pwrite && (paddr[2] == REG_BUFFER_BYTES);
    assign wr_ext  = {1'b0, pwdata};
    assign rst_ext = {1'b0, BUF_BYTES_RST};

    // Hold the raw size and the end of the usable buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= BUF_BYTES_RST;
            r_buf_end   <= (rst_ext > LIMIT) ? LIMIT : rst_ext;
        end else if (wr_en) begin
            r_buf_bytes <= pwdata;
            r_buf_end   <= (wr_ext > LIMIT) ? LIMIT : wr_ext;
        end
    end

    // Read back the register word
    assign prdata    = (paddr[2] == REG_BUFFER_BYTES) ? r_buf_bytes : '0;
    assign pready    = 1'b1;
    assign o_buf_end = r_buf_end;

endmodule

FILE: rtl/ffra_ctrl.sv
// Sequencer: scans the table, shifts entries and forms the result word
module ffra_ctrl
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_opcode,
    input  logic [DATA_W-1:0] i_req_size,
    input  logic [DATA_W-1:0] i_req_offset,
    input  logic [END_W-1:0]  i_buf_end,
    output logic              o_we,
    output logic [IDX_W-1:0]  o_waddr,
    output t_entry            o_wdata,
    output logic [IDX_W-1:0]  o_raddr,
    input  t_entry            i_rd_data,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_grant_offset
);

    t_state            r_state, n_state;
    logic              r_op, n_op;
    logic [DATA_W-1:0] r_size, n_size;
    logic [DATA_W-1:0] r_off, n_off;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_src, n_src;
    logic              r_up, n_up;
    logic [END_W-1:0]  r_prev_end, n_prev_end;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_grant, n_grant;

    logic [END_W-1:0]  ent_off;
    logic [END_W-1:0]  ent_end;
    logic [END_W-1:0]  req_ext;
    logic [END_W-1:0]  gap;
    logic [END_W-1:0]  tail_gap;
    logic              fit_gap;
    logic              fit_tail;
    logic              hit;
    logic              idx_last;
    logic              src_last;
    logic              accept;

    // Gap and match tests on the entry just read
    assign ent_off  = {1'b0, i_rd_data.offset};
    assign ent_end  = ent_off + {1'b0, i_rd_data.size};
    assign req_ext  = {1'b0, r_size};
    assign gap      = ent_off - r_prev_end;
    assign fit_gap  = (ent_off >= r_prev_end) && (gap >= req_ext);
    assign tail_gap = i_buf_end - r_prev_end;
    assign fit_tail = (i_buf_end >= r_prev_end) && (tail_gap >= req_ext);
    assign hit      = (i_rd_data.offset == r_off) && (i_rd_data.size == r_size);
    assign idx_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign src_last = (CNT_W'(r_src) + CNT_W'(1)) == r_count;
    assign accept   = i_start && (r_state == S_IDLE);

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_size     <= n_size;
        r_off      <= n_off;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_src      <= n_src;
        r_up       <= n_up;
        r_prev_end <= n_prev_end;
        r_status   <= n_status;
        r_grant    <= n_grant;
    end

    // Next state, memory accesses and result word
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_size     = r_size;
        n_off      = r_off;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_src      = r_src;
        n_up       = r_up;
        n_prev_end = r_prev_end;
        n_done     = 1'b0;
        n_status   = r_status;
        n_grant    = r_grant;
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = '0;
        o_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                // Entry 0 is read every idle cycle, ready for a scan
                if (accept) begin
                    n_op       = i_opcode;
                    n_size     = i_req_size;
                    n_off      = i_req_offset;
                    n_prev_end = '0;
                    n_idx      = '0;
                    if (i_opcode == OP_ALLOC) begin
                        if ((i_req_size == '0) || (r_count == CNT_W'(MAX_RANGES))) begin
                            n_done   = 1'b1;
                            n_status = ST_BAD;
                            n_grant  = '0;
                        end else if (r_count == '0) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_grant  = '0;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                o_raddr = r_idx + IDX_W'(1);
                if (r_op == OP_ALLOC) begin
                    if (fit_gap) begin
                        // Open a slot at this entry: shift the tail up
                        n_pos   = r_idx;
                        n_src   = IDX_W'(r_count - CNT_W'(1));
                        n_up    = 1'b1;
                        o_raddr = IDX_W'(r_count - CNT_W'(1));
                        n_state = S_MOVE;
                    end else begin
                        if (ent_end > r_prev_end) begin
                            n_prev_end = ent_end;
                        end
                        if (idx_last) begin
                            n_state = S_TAIL;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end else begin
                    if (hit) begin
                        if (idx_last) begin
                            n_count  = r_count - CNT_W'(1);
                            n_done   = 1'b1;
                            n_status = ST_OK;
                            n_grant  = '0;
                            n_state  = S_IDLE;
                        end else begin
                            // Close the hole: shift the tail down
                            n_src   = r_idx + IDX_W'(1);
                            n_up    = 1'b0;
                            n_state = S_MOVE;
                        end
                    end else if (idx_last) begin
                        n_done   = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_grant  = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            S_TAIL: begin
                // Try the gap up to the end of the buffer
                if (fit_tail) begin
                    n_pos   = IDX_W'(r_count);
                    n_state = S_PUT;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NOFIT;
                    n_grant  = '0;
                    n_state  = S_IDLE;
                end
            end

            S_MOVE: begin
                // Copy one entry a cycle; shifting up writes above the source and reads below it, down the reverse
                o_we    = 1'b1;
                o_wdata = i_rd_data;
                if (r_up) begin
                    o_waddr = r_src + IDX_W'(1);
                    o_raddr = r_src - IDX_W'(1);
                    if (r_src == r_pos) begin
                        n_state = S_PUT;
                    end else begin
                        n_src = r_src - IDX_W'(1);
                    end
                end else begin
                    o_waddr = r_src - IDX_W'(1);
                    o_raddr = r_src + IDX_W'(1);
                    if (src_last) begin
                        n_count  = r_count - CNT_W'(1);
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_grant  = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_src = r_src + IDX_W'(1);
                    end
                end
            end

            S_PUT: begin
                // Drop the new range into its slot
                o_we           = 1'b1;
                o_waddr        = r_pos;
                o_wdata.offset = r_prev_end[DATA_W-1:0];
                o_wdata.size   = r_size;
                n_count        = r_count + CNT_W'(1);
                n_done         = 1'b1;
                n_status       = ST_OK;
                n_grant        = r_prev_end[DATA_W-1:0];
                n_state        = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_grant_offset = r_grant;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_RANGES), "live count above table depth")
    `ASSERT_IMPL(a_fail_grant_zero, i_clk, i_rst_n, r_done && (r_status != ST_OK), r_grant == '0, "grant not zero on failure")
    `ASSERT_IMPL(a_alloc_grows, i_clk, i_rst_n, r_done && (r_status == ST_OK) && (r_op == OP_ALLOC), r_count == CNT_W'($past(r_count) + CNT_W'(1)), "allocate did not add an entry")
    `ASSERT_IMPL(a_release_shrinks, i_clk, i_rst_n, r_done && (r_status == ST_OK) && (r_op == OP_RELEASE), r_count == CNT_W'($past(r_count) - CNT_W'(1)), "release did not drop an entry")
    `ASSERT_NEXT(a_move_no_accept, i_clk, i_rst_n, r_state == S_MOVE, r_state != S_IDLE || r_done, "shift ended without a result")

endmodule
